// File: hdl/rwl_pkg.sv
// Shared types, codes and defaults for the reader-writer lock arbiter.
package rwl_pkg;

  // Default number of requesters; also the depth of each waiting queue
  localparam int unsigned NUM_REQ_DEF = 16;

  // Width of a requester number
  localparam int unsigned ID_W = 4;

  // Request commands
  localparam logic [1:0] CMD_ENTER_RD = 2'd0;
  localparam logic [1:0] CMD_EXIT_RD  = 2'd1;
  localparam logic [1:0] CMD_ENTER_WR = 2'd2;
  localparam logic [1:0] CMD_EXIT_WR  = 2'd3;

  // Result events
  localparam logic [2:0] EV_GRANT    = 3'd0;
  localparam logic [2:0] EV_QUEUED   = 3'd1;
  localparam logic [2:0] EV_RELEASED = 3'd2;
  localparam logic [2:0] EV_WOKEN    = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  // Error kinds
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_EXIT = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;

  // Input word
  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] requester;
  } req_t;

  // Output word
  typedef struct packed {
    logic [2:0]      event_res;
    logic [ID_W-1:0] client;
    logic            as_writer;
    logic [1:0]      error_kind;
    logic [4:0]      reader_count;
    logic            last;
  } res_t;

  // Operation on the active reader counter
  typedef enum logic [1:0] {
    RD_HOLD,
    RD_INC,
    RD_DEC
  } rd_op_e;

  // Waiting queue occupancy flags
  typedef struct packed {
    logic empty;
    logic single;
    logic full;
  } fifo_stat_t;

  // Active reader counter flags
  typedef struct packed {
    logic zero;
    logic one;
    logic full;
  } rd_stat_t;

endpackage

// File: hdl/rwl_fifo.sv
// Waiting queue of requester numbers: circular memory with head, tail and count.
module rwl_fifo #(
  parameter int unsigned DEPTH = rwl_pkg::NUM_REQ_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      pop_i,
  input  logic [rwl_pkg::ID_W-1:0]  wdata_i,
  output logic [rwl_pkg::ID_W-1:0]  rdata_o,
  output rwl_pkg::fifo_stat_t       stat_o
);
  import rwl_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [PW-1:0]   head_q, head_d;
  logic [PW-1:0]   tail_q, tail_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rdata_q;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Advance pointers and occupancy
  always_comb begin
    head_d = pop_i  ? wrap_inc(head_q) : head_q;
    tail_d = push_i ? wrap_inc(tail_q) : tail_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Write at tail, read head into a register
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= wdata_i;
    end
    rdata_q <= mem_q[head_q];
  end

  assign rdata_o       = rdata_q;
  assign stat_o.empty  = (cnt_q == '0);
  assign stat_o.single = (cnt_q == CW'(1));
  assign stat_o.full   = (cnt_q == CW'(DEPTH));

endmodule

// File: hdl/rwl_rdcnt.sv
// Active reader counter: shared increment, decrement and limit compare.
module rwl_rdcnt #(
  parameter int unsigned NUM_REQUESTERS = rwl_pkg::NUM_REQ_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rwl_pkg::rd_op_e                      op_i,
  output logic [$clog2(NUM_REQUESTERS+1)-1:0]  next_o,
  output rwl_pkg::rd_stat_t                    stat_o
);
  import rwl_pkg::*;

  localparam int unsigned CW = $clog2(NUM_REQUESTERS + 1);

  logic [CW-1:0] cnt_q, cnt_d;

  // Saturate at both ends
  always_comb begin
    cnt_d = cnt_q;
    case (op_i)
      RD_INC:  cnt_d = stat_o.full ? cnt_q : cnt_q + CW'(1);
      RD_DEC:  cnt_d = stat_o.zero ? cnt_q : cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign next_o      = cnt_d;
  assign stat_o.zero = (cnt_q == '0);
  assign stat_o.one  = (cnt_q == CW'(1));
  assign stat_o.full = (cnt_q == CW'(NUM_REQUESTERS));

endmodule

// File: hdl/reader_writer_lock_arbiter_core.sv
// Reader-writer lock arbiter top level: request sequencer and result register.
// Takes one lock request word at a time (enter/exit read, enter/exit write) and
// answers with one or more result words, the final one marked by last. A request
// is taken in S_IDLE and decided in S_EXEC once the output register is free.
// A writer exit that wakes waiting readers emits one word per reader from
// S_DRAIN: the reader queue memory has one registered read port, so each wake
// pops the head and passes through S_GAP while the next head word is read.
// in_stall_o stays high from acceptance until the last result word is loaded
// into the output register; that register lets the next request be taken while
// a result still waits on out_stall_i. The waiting queues need no clearing pass.
module reader_writer_lock_arbiter_core #(
  parameter int unsigned NUM_REQUESTERS = rwl_pkg::NUM_REQ_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rwl_pkg::req_t in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rwl_pkg::res_t out_word_o
);
  import rwl_pkg::*;

  localparam int unsigned CW = $clog2(NUM_REQUESTERS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_GAP   = 2'd3;

  logic [1:0]      state_q, state_d;
  req_t            req_q;
  logic            wr_hold_q, wr_hold_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;
  res_t            res;
  logic            emit;
  logic            out_free;
  logic            in_take;

  rd_op_e          rd_op;
  logic [CW-1:0]   rd_next;
  logic [CW+4:0]   rd_next_ext;
  rd_stat_t        rd_stat;

  logic            rq_push, rq_pop, wq_push, wq_pop;
  logic [ID_W-1:0] rq_data, wq_data;
  fifo_stat_t      rq_stat, wq_stat;

  rwl_rdcnt #(
    .NUM_REQUESTERS(NUM_REQUESTERS)
  ) u_rdcnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (rd_op),
    .next_o (rd_next),
    .stat_o (rd_stat)
  );

  rwl_fifo #(
    .DEPTH(NUM_REQUESTERS)
  ) u_rd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .pop_i   (rq_pop),
    .wdata_i (req_q.requester),
    .rdata_o (rq_data),
    .stat_o  (rq_stat)
  );

  rwl_fifo #(
    .DEPTH(NUM_REQUESTERS)
  ) u_wr_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .pop_i   (wq_pop),
    .wdata_i (req_q.requester),
    .rdata_o (wq_data),
    .stat_o  (wq_stat)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequence one request: decide, then drain woken readers one word at a time
  always_comb begin
    state_d       = state_q;
    wr_hold_d     = wr_hold_q;
    rd_op         = RD_HOLD;
    rq_push       = 1'b0;
    rq_pop        = 1'b0;
    wq_push       = 1'b0;
    wq_pop        = 1'b0;
    emit          = 1'b0;
    res           = '0;
    res.client    = req_q.requester;
    res.as_writer = (req_q.command == CMD_ENTER_WR) || (req_q.command == CMD_EXIT_WR);
    res.last      = 1'b1;
    res.event_res = EV_RELEASED;
    res.error_kind = ERR_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          emit    = 1'b1;
          case (req_q.command)
            CMD_ENTER_RD: begin
              if (!wr_hold_q && wq_stat.empty) begin
                if (rd_stat.full) begin
                  res.event_res  = EV_ERROR;
                  res.error_kind = ERR_FULL;
                end else begin
                  rd_op         = RD_INC;
                  res.event_res = EV_GRANT;
                end
              end else if (rq_stat.full) begin
                res.event_res  = EV_ERROR;
                res.error_kind = ERR_FULL;
              end else begin
                rq_push       = 1'b1;
                res.event_res = EV_QUEUED;
              end
            end
            CMD_EXIT_RD: begin
              if (rd_stat.zero) begin
                res.event_res  = EV_ERROR;
                res.error_kind = ERR_EXIT;
              end else begin
                rd_op = RD_DEC;
                if (rd_stat.one && !wq_stat.empty) begin
                  wq_pop        = 1'b1;
                  wr_hold_d     = 1'b1;
                  res.event_res = EV_WOKEN;
                  res.client    = wq_data;
                  res.as_writer = 1'b1;
                end else begin
                  res.event_res = EV_RELEASED;
                end
              end
            end
            CMD_ENTER_WR: begin
              if (rd_stat.zero && !wr_hold_q) begin
                wr_hold_d     = 1'b1;
                res.event_res = EV_GRANT;
              end else if (wq_stat.full) begin
                res.event_res  = EV_ERROR;
                res.error_kind = ERR_FULL;
              end else begin
                wq_push       = 1'b1;
                res.event_res = EV_QUEUED;
              end
            end
            CMD_EXIT_WR: begin
              if (!wr_hold_q) begin
                res.event_res  = EV_ERROR;
                res.error_kind = ERR_EXIT;
              end else if (!rq_stat.empty) begin
                wr_hold_d = 1'b0;
                emit      = 1'b0;
                state_d   = S_DRAIN;
              end else if (!wq_stat.empty) begin
                wq_pop        = 1'b1;
                res.event_res = EV_WOKEN;
                res.client    = wq_data;
              end else begin
                wr_hold_d     = 1'b0;
                res.event_res = EV_RELEASED;
              end
            end
            default: begin
              res.event_res = EV_RELEASED;
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          emit          = 1'b1;
          rq_pop        = 1'b1;
          rd_op         = RD_INC;
          res.event_res = EV_WOKEN;
          res.client    = rq_data;
          res.as_writer = 1'b0;
          res.last      = rq_stat.single;
          state_d       = rq_stat.single ? S_IDLE : S_GAP;
        end
      end
      S_GAP: begin
        state_d = S_DRAIN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Load the output word, reader count taken after this word's update
  assign rd_next_ext = {5'b0, rd_next};

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d        = 1'b1;
      out_d              = res;
      out_d.reader_count = rd_next_ext[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_hold_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_hold_q   <= wr_hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold request and output payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= in_word_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTH
  // A writer never holds the lock together with active readers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_hold_q && !rd_stat.zero))
    else $error("writer holds lock while readers are active");

  // Draining only runs while readers wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> !rq_stat.empty)
    else $error("reader drain with empty reader queue");

  // Error kind is set only on error words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.event_res != EV_ERROR)) |->
      (out_word_o.error_kind == ERR_NONE))
    else $error("error kind set on a non-error word");

  // No new request is taken while a wake sequence is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DRAIN) || (state_q == S_GAP)) |-> in_stall_o)
    else $error("request taken during reader drain");
`endif

endmodule
